@@ rtl/slmf_pkg.sv @@
// Shared constants and types of the smallest strict local maximum finder.
package slmf_pkg;

    // Configuration port layout
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 9;

    // Width of the row and column fields of a result beat
    localparam int POS_OUT_WIDTH = 8;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_NUM_ROWS = 2'd0,
        CFG_NUM_COLS = 2'd1
    } t_cfg_reg;

endpackage

@@ rtl/slmf_if.sv @@
// Handshake interfaces of the local maximum finder: samples, results and configuration.
interface slmf_sample_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface slmf_result_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                                 valid;
    logic                                 ready;
    logic                                 found;
    logic [slmf_pkg::POS_OUT_WIDTH-1:0]   best_row;
    logic [slmf_pkg::POS_OUT_WIDTH-1:0]   best_col;
    logic signed [SAMPLE_WIDTH-1:0]       best_value;

    modport source (output valid, output found, output best_row, output best_col,
                    output best_value, input ready);
    modport sink   (input valid, input found, input best_row, input best_col,
                    input best_value, output ready);
endinterface

interface slmf_cfg_if ();
    logic                                 valid;
    logic                                 ready;
    logic [slmf_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [slmf_pkg::CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/slmf_ram.sv @@
// Simple dual-port RAM: one write port, one read port, registered read (old data on collision).
module slmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/smallest_strict_local_max_finder_top.sv @@
// Smallest strict 4-neighbor local maximum of a row-major sample stream.
// The block takes one sample per clock, num_rows x num_cols samples per matrix, and after
// the last sample of a matrix delivers one result beat (found flag, row, column, value of
// the smallest strict local maximum; first in row-major order on ties; zeros if none).
// Two line buffers in RAM hold the previous row and the row before it; the previous row is
// read one column ahead of the incoming sample, so every position is judged exactly when its
// lower neighbor arrives; the last row is judged on the fly as its right neighbor arrives.
// The result passes through stages B, C and D and then waits in an eight-beat result queue;
// the input stalls on a matrix-final sample while eight results are queued or in flight,
// and in any cycle in which a configuration beat is taken.
// Line buffers need no clearing pass: entries read before they are written never reach a result.
// A write to either configuration register restarts the matrix; it is taken only while
// no sample is in stages B, C or D.
module smallest_strict_local_max_finder_top #(
    parameter int MAX_ROWS     = 256,
    parameter int MAX_COLS     = 256,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    slmf_sample_if.sink     i_sample,
    slmf_result_if.source   o_result,
    slmf_cfg_if.sink        i_cfg
);

    localparam int SW        = SAMPLE_WIDTH;
    localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW        = $clog2(MAX_COLS);
    localparam int DW        = slmf_pkg::CFG_DATA_WIDTH;
    localparam int POW       = slmf_pkg::POS_OUT_WIDTH;
    localparam int KW        = SW + RW + CW;
    localparam int RES_DEPTH = 8;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int PW        = RES_AW + 2;

    typedef struct packed {
        logic                 valid;
        logic signed [SW-1:0] value;
        logic [RW-1:0]        row;
        logic [CW-1:0]        col;
    } t_cand;

    typedef struct packed {
        logic                 found;
        logic [POW-1:0]       best_row;
        logic [POW-1:0]       best_col;
        logic signed [SW-1:0] best_value;
    } t_result;

    // Ordering key: value first (sign flipped for unsigned compare), then row-major position
    function automatic logic [KW-1:0] cand_key(input t_cand c);
        cand_key = {~c.value[SW-1], c.value[SW-2:0], c.row, c.col};
    endfunction

    // Keeps the smaller of two candidates; an invalid side never wins
    function automatic t_cand pick_best(input t_cand a, input t_cand b);
        priority if (!b.valid) begin
            pick_best = a;
        end else if (!a.valid) begin
            pick_best = b;
        end else if (cand_key(b) < cand_key(a)) begin
            pick_best = b;
        end else begin
            pick_best = a;
        end
    endfunction

    // Strict maximum test; a missing neighbor never blocks
    function automatic logic is_peak(
        input logic signed [SW-1:0] ctr,
        input logic has_up,    input logic signed [SW-1:0] up,
        input logic has_right, input logic signed [SW-1:0] right,
        input logic has_down,  input logic signed [SW-1:0] down,
        input logic has_left,  input logic signed [SW-1:0] left
    );
        is_peak = (!has_up || (ctr > up)) && (!has_right || (ctr > right)) &&
                  (!has_down || (ctr > down)) && (!has_left || (ctr > left));
    endfunction

    // ------------------------------------------------------------------
    // Configuration and position counters
    // ------------------------------------------------------------------
    logic [RW-1:0] r_last_row;
    logic [CW-1:0] r_last_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [RW-1:0] n_cfg_last_row;
    logic [CW-1:0] n_cfg_last_col;
    logic          cfg_fire;
    logic          cfg_restart;

    assign cfg_fire    = i_cfg.valid && i_cfg.ready;

    // Size registers hold the last index; zero acts as one, oversize saturates
    always_comb begin
        if (i_cfg.data == '0) begin
            n_cfg_last_row = '0;
            n_cfg_last_col = '0;
        end else begin
            n_cfg_last_row = (32'(i_cfg.data) > MAX_ROWS) ? RW'(MAX_ROWS - 1)
                                                          : RW'(i_cfg.data - DW'(1));
            n_cfg_last_col = (32'(i_cfg.data) > MAX_COLS) ? CW'(MAX_COLS - 1)
                                                          : CW'(i_cfg.data - DW'(1));
        end
    end

    assign cfg_restart = cfg_fire &&
        ((i_cfg.index == slmf_pkg::CFG_NUM_ROWS) || (i_cfg.index == slmf_pkg::CFG_NUM_COLS));

    logic          in_fire;
    logic          a_last_row;
    logic          a_last_col;
    logic          a_end;
    logic [CW-1:0] a_rd_addr;

    assign a_last_row = (r_row == r_last_row);
    assign a_last_col = (r_col == r_last_col);
    assign a_end      = a_last_row && a_last_col;
    // Read one column ahead; at row end fetch column 0 of the row just finished
    assign a_rd_addr  = a_last_col ? '0 : CW'(r_col + CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_row <= '0;
            r_last_col <= '0;
            r_row      <= '0;
            r_col      <= '0;
        end else if (cfg_fire) begin
            unique case (i_cfg.index)
                slmf_pkg::CFG_NUM_ROWS: begin
                    r_last_row <= n_cfg_last_row;
                    r_row      <= '0;
                    r_col      <= '0;
                end
                slmf_pkg::CFG_NUM_COLS: begin
                    r_last_col <= n_cfg_last_col;
                    r_row      <= '0;
                    r_col      <= '0;
                end
                default: begin
                end
            endcase
        end else if (in_fire) begin
            if (a_last_col) begin
                r_col <= '0;
                r_row <= a_last_row ? '0 : RW'(r_row + RW'(1));
            end else begin
                r_col <= CW'(r_col + CW'(1));
            end
        end
    end

    // ------------------------------------------------------------------
    // Input acceptance and flow control
    // ------------------------------------------------------------------
    logic                r_b_valid;
    logic                r_b_end;
    logic                r_c_valid;
    logic                r_c_end;
    logic                r_d_valid;
    logic                r_d_end;
    logic [RES_AW:0]     r_count;
    logic [PW-1:0]       pending;

    // Results queued plus matrix-final samples still in the pipeline
    assign pending = PW'(r_count) + PW'(r_b_valid && r_b_end) + PW'(r_c_valid && r_c_end)
                   + PW'(r_d_valid && r_d_end);

    // Config waits for an empty pipeline; a config beat holds off the sample input
    assign i_cfg.ready    = !(r_b_valid || r_c_valid || r_d_valid);
    assign i_sample.ready = !cfg_fire && (!a_end || (pending < PW'(RES_DEPTH)));
    assign in_fire        = i_sample.valid && i_sample.ready;

    // ------------------------------------------------------------------
    // Line buffers
    // ------------------------------------------------------------------
    logic signed [SW-1:0] r_ctr;
    logic signed [SW-1:0] mem1_q;
    logic signed [SW-1:0] mem2_q;
    logic [RW-1:0]        r_b_row;
    logic [CW-1:0]        r_b_col;
    logic                 b_row_ge1;

    // Row just above; the current row overwrites it as it arrives
    slmf_ram #(.WIDTH(SW), .DEPTH(MAX_COLS)) u_row_one_back (
        .i_clk   (i_clk),
        .i_we    (in_fire),
        .i_waddr (r_col),
        .i_wdata (i_sample.sample),
        .i_re    (in_fire),
        .i_raddr (a_rd_addr),
        .o_rdata (mem1_q)
    );

    // Row two above; takes the old upper-row value as each column is judged
    slmf_ram #(.WIDTH(SW), .DEPTH(MAX_COLS)) u_row_two_back (
        .i_clk   (i_clk),
        .i_we    (r_b_valid && b_row_ge1),
        .i_waddr (r_b_col),
        .i_wdata (r_ctr),
        .i_re    (in_fire),
        .i_raddr (r_col),
        .o_rdata (mem2_q)
    );

    // ------------------------------------------------------------------
    // Stage B: window and neighbor tests
    // ------------------------------------------------------------------
    logic signed [SW-1:0] r_b_v;
    logic                 r_b_last_row;
    logic                 r_b_last_col;
    logic                 r_b_fwd1;
    logic                 r_b_fwd2;
    logic signed [SW-1:0] r_b_fwd2_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_b_v        <= i_sample.sample;
            r_b_row      <= r_row;
            r_b_col      <= r_col;
            r_b_last_row <= a_last_row;
            r_b_last_col <= a_last_col;
            r_b_end      <= a_end;
            // single column: the look-ahead read hits the entry written this cycle
            r_b_fwd1     <= (a_rd_addr == r_col);
            // upper-row read collides with the write of the beat ahead
            r_b_fwd2     <= r_b_valid && (r_b_col == r_col);
            r_b_fwd2_val <= r_ctr;
        end
    end

    logic signed [SW-1:0] r_left;
    logic signed [SW-1:0] r_pv;
    logic signed [SW-1:0] r_ppv;
    logic signed [SW-1:0] right_raw;
    logic signed [SW-1:0] up_raw;
    logic                 b_row_ge2;
    logic                 b_col_ge1;
    logic                 b_col_ge2;
    t_cand                b_cand [3];

    assign right_raw = r_b_fwd1 ? r_b_v : mem1_q;
    assign up_raw    = r_b_fwd2 ? r_b_fwd2_val : mem2_q;
    assign b_row_ge1 = (r_b_row != '0);
    assign b_row_ge2 = b_row_ge1 && (r_b_row != RW'(1));
    assign b_col_ge1 = (r_b_col != '0);
    assign b_col_ge2 = b_col_ge1 && (r_b_col != CW'(1));

    always_comb begin
        // upper row position above the sample
        b_cand[0].valid = b_row_ge1 && is_peak(r_ctr, b_row_ge2, up_raw,
                                               !r_b_last_col, right_raw,
                                               1'b1, r_b_v, b_col_ge1, r_left);
        b_cand[0].value = r_ctr;
        b_cand[0].row   = RW'(r_b_row - RW'(1));
        b_cand[0].col   = r_b_col;
        // last row: position left of the sample
        b_cand[1].valid = r_b_last_row && b_col_ge1 &&
                          is_peak(r_pv, b_row_ge1, r_left, 1'b1, r_b_v,
                                  1'b0, '0, b_col_ge2, r_ppv);
        b_cand[1].value = r_pv;
        b_cand[1].row   = r_b_row;
        b_cand[1].col   = CW'(r_b_col - CW'(1));
        // last sample of the matrix: the sample itself
        b_cand[2].valid = r_b_last_row && r_b_last_col &&
                          is_peak(r_b_v, b_row_ge1, r_ctr, 1'b0, '0,
                                  1'b0, '0, b_col_ge1, r_pv);
        b_cand[2].value = r_b_v;
        b_cand[2].row   = r_b_row;
        b_cand[2].col   = r_b_col;
    end

    // Sliding window over the upper row and the current row
    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_left <= r_ctr;
            r_ctr  <= right_raw;
            r_pv   <= r_b_v;
            r_ppv  <= r_pv;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: reduce up to three candidates
    // ------------------------------------------------------------------
    t_cand r_c_cand [3];
    t_cand r_d_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_c_cand <= b_cand;
            r_c_end  <= r_b_end;
        end
        if (r_c_valid) begin
            r_d_cand <= pick_best(pick_best(r_c_cand[0], r_c_cand[1]), r_c_cand[2]);
            r_d_end  <= r_c_end;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: running best and result
    // ------------------------------------------------------------------
    t_cand   r_best;
    t_cand   n_best;
    t_result n_result;
    logic    push;

    assign n_best = pick_best(r_best, r_d_cand);
    assign push   = r_d_valid && r_d_end;

    always_comb begin
        n_result.found      = n_best.valid;
        n_result.best_row   = n_best.valid ? POW'(n_best.row) : '0;
        n_result.best_col   = n_best.valid ? POW'(n_best.col) : '0;
        n_result.best_value = n_best.valid ? n_best.value : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else if (cfg_restart) begin
            r_best <= '0;
        end else if (r_d_valid) begin
            r_best <= r_d_end ? '0 : n_best;
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    t_result           r_fifo [RES_DEPTH];
    logic [RES_AW-1:0] r_wr_ptr;
    logic [RES_AW-1:0] r_rd_ptr;
    logic              pop;

    assign pop = o_result.valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= RES_AW'(r_wr_ptr + RES_AW'(1));
            end
            if (pop) begin
                r_rd_ptr <= RES_AW'(r_rd_ptr + RES_AW'(1));
            end
            unique case ({push, pop})
                2'b10:   r_count <= (RES_AW+1)'(r_count + (RES_AW+1)'(1));
                2'b01:   r_count <= (RES_AW+1)'(r_count - (RES_AW+1)'(1));
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_result.valid      = (r_count != '0);
    assign o_result.found      = r_fifo[r_rd_ptr].found;
    assign o_result.best_row   = r_fifo[r_rd_ptr].best_row;
    assign o_result.best_col   = r_fifo[r_rd_ptr].best_col;
    assign o_result.best_value = r_fifo[r_rd_ptr].best_value;

endmodule
